// File: rtl/aiff_pkg.sv
// shared types, codes and helpers for the aiff chunk sample parser
// no dependencies; used by aiff_rem_unit and aiff_chunk_sample_parser_unit
package aiff_pkg;

	localparam int unsigned MaxChannelsDefault = 16;

	localparam logic [31:0] ID_COMM = 32'h434F4D4D;
	localparam logic [31:0] ID_SSND = 32'h53534E44;

	typedef enum logic [3:0] {
		PH_ID,
		PH_SIZE,
		PH_BODY,
		PH_SSND_HDR,
		PH_SKIP,
		PH_DATA,
		PH_DONE,
		PH_ERR
	} phase_t;

	typedef enum logic [1:0] {
		REM_IDLE,
		REM_LOOP,
		REM_FIX
	} rem_state_t;

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_ERROR  = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;

	localparam logic [1:0] ERR_BITS    = 2'd0;
	localparam logic [1:0] ERR_CHANS   = 2'd1;
	localparam logic [1:0] ERR_RATE    = 2'd2;
	localparam logic [1:0] ERR_OVERRUN = 2'd3;

	// bit 2 set when the header is bad, low bits give the error code
	function automatic logic [2:0] hdr_check(input logic [15:0] bits, input logic [15:0] chans,
			input logic rate, input logic [15:0] max_ch);
		logic [2:0] r;
		r = 3'b000;
		if (bits != 16'd8 && bits != 16'd16 && bits != 16'd32) begin
			r = {1'b1, ERR_BITS};
		end else if (chans == 16'd0 || chans > max_ch) begin
			r = {1'b1, ERR_CHANS};
		end else if (!rate) begin
			r = {1'b1, ERR_RATE};
		end
		return r;
	endfunction

endpackage

// File: rtl/aiff_rem_unit.sv
// bit-serial remainder unit that rounds the frame size up to a block size multiple
// depends on aiff_pkg
module aiff_rem_unit #(
	parameter int unsigned MINB_W = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  logic              start,
	input  logic [MINB_W-1:0] minb,
	input  logic [31:0]       divisor,
	output logic              busy,
	output logic [32:0]       stride
);
	import aiff_pkg::*;

	localparam int unsigned CNT_W = $clog2(MINB_W + 1);

	rem_state_t        state_q, state_d;
	logic [31:0]       rem_q, rem_d;
	logic [MINB_W-1:0] dvd_q, dvd_d;
	logic [MINB_W-1:0] minb_q, minb_d;
	logic [31:0]       div_q, div_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [32:0]       stride_q, stride_d;
	logic [32:0]       trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= REM_IDLE;
			stride_q <= '0;
			cnt_q    <= '0;
		end else begin
			state_q  <= state_d;
			stride_q <= stride_d;
			cnt_q    <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= rem_d;
		dvd_q  <= dvd_d;
		minb_q <= minb_d;
		div_q  <= div_d;
	end

	always_comb begin
		state_d  = state_q;
		rem_d    = rem_q;
		dvd_d    = dvd_q;
		minb_d   = minb_q;
		div_d    = div_q;
		cnt_d    = cnt_q;
		stride_d = stride_q;
		trial    = {rem_q, dvd_q[MINB_W-1]};
		unique case (state_q)
			REM_IDLE: begin
				if (clr) begin
					stride_d = '0;
				end else if (start) begin
					minb_d = minb;
					div_d  = divisor;
					if (divisor == 32'd0) begin
						stride_d = {{(33-MINB_W){1'b0}}, minb};
					end else begin
						rem_d   = '0;
						dvd_d   = minb;
						cnt_d   = CNT_W'(MINB_W);
						state_d = REM_LOOP;
					end
				end
			end
			REM_LOOP: begin
				if (trial >= {1'b0, div_q}) begin
					trial = trial - {1'b0, div_q};
				end
				rem_d = trial[31:0];
				dvd_d = dvd_q << 1;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					state_d = REM_FIX;
				end
			end
			REM_FIX: begin
				if (rem_q == 32'd0) begin
					stride_d = {{(33-MINB_W){1'b0}}, minb_q};
				end else begin
					stride_d = {{(33-MINB_W){1'b0}}, minb_q} + {1'b0, div_q} - {1'b0, rem_q};
				end
				state_d = REM_IDLE;
			end
			default: state_d = REM_IDLE;
		endcase
	end

	assign busy   = (state_q != REM_IDLE);
	assign stride = stride_q;

endmodule

// File: rtl/aiff_chunk_sample_parser_unit.sv
// top level of the aiff chunk sample parser: byte sequencer, header registers, result register
// depends on aiff_pkg and aiff_rem_unit
//
// The parser takes one byte of the chunk region per beat while in_stall is low; a result that a
// byte yields is registered and shown in the next cycle. At the last offset/block size byte of a
// sound chunk with a nonzero block size the frame-size rounding runs on the bit-serial remainder
// unit, which holds in_stall high while it runs. A result waits in the output register while
// in_stall stays high until it is taken. Writing region_bytes restarts the parser.
module aiff_chunk_sample_parser_unit #(
	parameter int unsigned MAX_CHANNELS = aiff_pkg::MaxChannelsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         in_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         out_kind,
	output logic signed [31:0] sample_value,
	output logic [3:0]         channel_index,
	output logic               frame_last,
	output logic [1:0]         error_code
);
	import aiff_pkg::*;

	localparam int unsigned CH_W   = $clog2(MAX_CHANNELS + 1);
	localparam int unsigned MINB_W = CH_W + 2;
	localparam logic [15:0] MaxCh  = 16'(MAX_CHANNELS);

	logic        cfg_wr;
	logic        in_acc;
	logic        rem_busy;
	logic        rem_start;
	logic [MINB_W-1:0] minb;
	logic [32:0] frame_stride;

	phase_t      phase_q, phase_d;
	logic [31:0] region_bytes_q;
	logic [31:0] fbc_q, fbc_d;
	logic [31:0] chunk_id_q, chunk_id_d;
	logic [31:0] chunk_len_q, chunk_len_d;
	logic [31:0] region_left_q, region_left_d;
	logic [31:0] body_left_q, body_left_d;
	logic [15:0] chan_cnt_q, chan_cnt_d;
	logic [15:0] sample_bits_q, sample_bits_d;
	logic        rate_q, rate_d;
	logic [31:0] skip_q, skip_d;
	logic [31:0] align_q, align_d;
	logic [31:0] sound_left_q, sound_left_d;
	logic [32:0] shift_q, shift_d;
	logic [CH_W-1:0] chan_pos_q, chan_pos_d;
	logic [1:0]  bis_q, bis_d;
	logic [31:0] accum_q, accum_d;
	logic [1:0]  err_q, err_d;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [31:0] value_q;
	logic [3:0]  chidx_q;
	logic        last_q;
	logic [1:0]  code_q;

	logic        emit;
	logic [1:0]  e_kind;
	logic [31:0] e_value;
	logic [3:0]  e_ch;
	logic        e_last;
	logic [1:0]  e_code;

	assign cfg_wr   = psel & penable & pwrite & pready;
	assign pready   = 1'b1;
	assign prdata   = region_bytes_q;
	assign in_stall = rem_busy | (out_valid_q & out_stall);
	assign in_acc   = in_valid & ~in_stall;

	always_comb begin
		unique case (sample_bits_q[5:3])
			3'd4:    minb = {chan_cnt_q[CH_W-1:0], 2'b00};
			3'd2:    minb = {1'b0, chan_cnt_q[CH_W-1:0], 1'b0};
			default: minb = {2'b00, chan_cnt_q[CH_W-1:0]};
		endcase
	end

	aiff_rem_unit #(
		.MINB_W(MINB_W)
	) u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (cfg_wr),
		.start  (rem_start),
		.minb   (minb),
		.divisor(align_d),
		.busy   (rem_busy),
		.stride (frame_stride)
	);

	always_comb begin
		logic        do_fin;
		logic        failed;
		logic [2:0]  chk;
		logic [32:0] need;
		logic [31:0] pos;
		logic [31:0] avail;
		logic [2:0]  bps;
		logic [31:0] v;
		logic [32:0] ss_inc;
		phase_d       = phase_q;
		fbc_d         = fbc_q;
		chunk_id_d    = chunk_id_q;
		chunk_len_d   = chunk_len_q;
		region_left_d = region_left_q;
		body_left_d   = body_left_q;
		chan_cnt_d    = chan_cnt_q;
		sample_bits_d = sample_bits_q;
		rate_d        = rate_q;
		skip_d        = skip_q;
		align_d       = align_q;
		sound_left_d  = sound_left_q;
		shift_d       = shift_q;
		chan_pos_d    = chan_pos_q;
		bis_d         = bis_q;
		accum_d       = accum_q;
		err_d         = err_q;
		emit          = 1'b0;
		e_kind        = KIND_SAMPLE;
		e_value       = '0;
		e_ch          = '0;
		e_last        = 1'b0;
		e_code        = '0;
		rem_start     = 1'b0;
		do_fin        = 1'b0;
		failed        = 1'b0;
		chk           = '0;
		need          = '0;
		pos           = fbc_q;
		avail         = chunk_len_q - 32'd8;
		bps           = sample_bits_q[5:3];
		v             = '0;
		ss_inc        = shift_q + 33'd1;
		if (in_acc) begin
			unique case (phase_q)
				PH_ERR: begin
					emit   = 1'b1;
					e_kind = KIND_ERROR;
					e_code = err_q;
				end
				PH_DONE: begin
					emit   = 1'b1;
					e_kind = KIND_DONE;
				end
				PH_ID: begin
					if (fbc_q == 32'd0 && region_left_q == 32'd0) begin
						phase_d = PH_DONE;
						emit    = 1'b1;
						e_kind  = KIND_DONE;
					end else if (fbc_q == 32'd0 && region_left_q < 32'd8) begin
						failed = 1'b1;
						chk    = {1'b1, ERR_OVERRUN};
					end else begin
						chunk_id_d    = {chunk_id_q[23:0], in_byte};
						region_left_d = region_left_q - 32'd1;
						fbc_d         = fbc_q + 32'd1;
						if (fbc_q == 32'd3) begin
							fbc_d       = '0;
							chunk_len_d = '0;
							phase_d     = PH_SIZE;
						end
					end
				end
				PH_SIZE: begin
					chunk_len_d   = {chunk_len_q[23:0], in_byte};
					region_left_d = region_left_q - 32'd1;
					fbc_d         = fbc_q + 32'd1;
					if (fbc_q == 32'd3) begin
						fbc_d       = '0;
						need        = {1'b0, chunk_len_d} + {32'd0, chunk_len_d[0]};
						body_left_d = need[31:0];
						if (need > {1'b0, region_left_d}) begin
							failed = 1'b1;
							chk    = {1'b1, ERR_OVERRUN};
						end else begin
							if (chunk_id_q == ID_COMM) begin
								chan_cnt_d    = '0;
								sample_bits_d = '0;
								rate_d        = 1'b0;
								phase_d       = PH_BODY;
							end else if (chunk_id_q == ID_SSND) begin
								chk = hdr_check(sample_bits_q, chan_cnt_q, rate_q, MaxCh);
								if (chk[2]) begin
									failed = 1'b1;
								end else begin
									skip_d  = '0;
									align_d = '0;
									phase_d = PH_SSND_HDR;
								end
							end else begin
								phase_d = PH_BODY;
							end
							if (!failed && need == 33'd0) begin
								do_fin = 1'b1;
							end
						end
					end
				end
				default: begin
					region_left_d = region_left_q - 32'd1;
					body_left_d   = body_left_q - 32'd1;
					if (chunk_id_q == ID_COMM) begin
						if (pos < chunk_len_q) begin
							if (pos < 32'd2) begin
								chan_cnt_d = {chan_cnt_q[7:0], in_byte};
							end else if (pos == 32'd6 || pos == 32'd7) begin
								sample_bits_d = {sample_bits_q[7:0], in_byte};
							end else if (pos == 32'd8) begin
								if (in_byte[6:0] != 7'd0) rate_d = 1'b1;
							end else if (pos > 32'd8 && pos < 32'd18) begin
								if (in_byte != 8'd0) rate_d = 1'b1;
							end
						end
					end else if (phase_q == PH_SSND_HDR) begin
						if (pos < chunk_len_q) begin
							if (pos < 32'd4) begin
								skip_d = {skip_q[23:0], in_byte};
							end else if (pos < 32'd8) begin
								align_d = {align_q[23:0], in_byte};
							end
							if (pos == 32'd7) begin
								sound_left_d = (avail >= skip_d) ? avail - skip_d : 32'd0;
								shift_d      = '0;
								bis_d        = '0;
								accum_d      = '0;
								chan_pos_d   = '0;
								phase_d      = (skip_d != 32'd0) ? PH_SKIP : PH_DATA;
								rem_start    = 1'b1;
							end
						end
					end else if (phase_q == PH_SKIP) begin
						skip_d = skip_q - 32'd1;
						if (skip_d == 32'd0) phase_d = PH_DATA;
					end else if (phase_q == PH_DATA) begin
						if (shift_q == 33'd0 && (frame_stride == 33'd0 ||
								{1'b0, sound_left_q} < frame_stride)) begin
							phase_d = PH_BODY;
						end else begin
							if (shift_q < {{(33-MINB_W){1'b0}}, minb}) begin
								accum_d = {accum_q[23:0], in_byte};
								bis_d   = bis_q + 2'd1;
								if ({1'b0, bis_q} + 3'd1 >= bps) begin
									v = accum_d;
									if (bps == 3'd1 && v[7]) v[31:8] = '1;
									if (bps == 3'd2 && v[15]) v[31:16] = '1;
									emit    = 1'b1;
									e_kind  = KIND_SAMPLE;
									e_value = v;
									e_ch    = 4'(chan_pos_q);
									e_last  = (16'(chan_pos_q) + 16'd1 >= chan_cnt_q);
									chan_pos_d = e_last ? '0 : chan_pos_q + 1'b1;
									bis_d   = '0;
									accum_d = '0;
								end
							end
							shift_d = ss_inc;
							if (ss_inc >= frame_stride) begin
								shift_d      = '0;
								sound_left_d = sound_left_q - frame_stride[31:0];
							end
						end
					end
					fbc_d = fbc_q + 32'd1;
					if (body_left_d == 32'd0) do_fin = 1'b1;
				end
			endcase
			if (do_fin) begin
				if (chunk_id_d == ID_COMM) begin
					chk = hdr_check(sample_bits_d, chan_cnt_d, rate_d, MaxCh);
					if (chk[2]) failed = 1'b1;
				end
				if (!failed) begin
					phase_d    = PH_ID;
					fbc_d      = '0;
					chunk_id_d = '0;
					if (region_left_d == 32'd0) begin
						phase_d = PH_DONE;
						if (!emit) begin
							emit   = 1'b1;
							e_kind = KIND_DONE;
						end
					end
				end
			end
			if (failed) begin
				phase_d = PH_ERR;
				err_d   = chk[1:0];
				emit    = 1'b1;
				e_kind  = KIND_ERROR;
				e_value = '0;
				e_ch    = '0;
				e_last  = 1'b0;
				e_code  = chk[1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_ID;
			region_bytes_q <= '0;
			fbc_q          <= '0;
			chunk_id_q     <= '0;
			chunk_len_q    <= '0;
			region_left_q  <= '0;
			body_left_q    <= '0;
			chan_cnt_q     <= '0;
			sample_bits_q  <= '0;
			rate_q         <= 1'b0;
			skip_q         <= '0;
			align_q        <= '0;
			sound_left_q   <= '0;
			shift_q        <= '0;
			chan_pos_q     <= '0;
			bis_q          <= '0;
			accum_q        <= '0;
			err_q          <= '0;
			out_valid_q    <= 1'b0;
		end else if (cfg_wr && paddr[2] == 1'b0) begin
			phase_q        <= PH_ID;
			region_bytes_q <= pwdata;
			fbc_q          <= '0;
			chunk_id_q     <= '0;
			chunk_len_q    <= '0;
			region_left_q  <= pwdata;
			body_left_q    <= '0;
			chan_cnt_q     <= '0;
			sample_bits_q  <= '0;
			rate_q         <= 1'b0;
			skip_q         <= '0;
			align_q        <= '0;
			sound_left_q   <= '0;
			shift_q        <= '0;
			chan_pos_q     <= '0;
			bis_q          <= '0;
			accum_q        <= '0;
			err_q          <= '0;
			out_valid_q    <= out_valid_q & out_stall;
		end else begin
			phase_q       <= phase_d;
			fbc_q         <= fbc_d;
			chunk_id_q    <= chunk_id_d;
			chunk_len_q   <= chunk_len_d;
			region_left_q <= region_left_d;
			body_left_q   <= body_left_d;
			chan_cnt_q    <= chan_cnt_d;
			sample_bits_q <= sample_bits_d;
			rate_q        <= rate_d;
			skip_q        <= skip_d;
			align_q       <= align_d;
			sound_left_q  <= sound_left_d;
			shift_q       <= shift_d;
			chan_pos_q    <= chan_pos_d;
			bis_q         <= bis_d;
			accum_q       <= accum_d;
			err_q         <= err_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= e_kind;
			value_q <= e_value;
			chidx_q <= e_ch;
			last_q  <= e_last;
			code_q  <= e_code;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_kind      = kind_q;
	assign sample_value  = value_q;
	assign channel_index = chidx_q;
	assign frame_last    = last_q;
	assign error_code    = code_q;

	// no byte taken while the remainder unit runs
	a_rem_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rem_busy |-> in_stall)
		else $error("byte accepted during block size rounding");

	// a byte in the finished state answers region finished
	a_done_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && phase_q == PH_DONE && !cfg_wr) |=> (out_valid && out_kind == KIND_DONE))
		else $error("finished region did not answer");

	// a latched error repeats its code
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && phase_q == PH_ERR && !cfg_wr) |=>
		(out_valid && out_kind == KIND_ERROR && error_code == $past(err_q)))
		else $error("latched error not repeated");

	// a new result never lands on one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !emit)
		else $error("pending result overwritten");

endmodule

// File: tb/testbench.sv
// self-checking testbench for aiff_chunk_sample_parser_unit: random AIFF chunk regions,
// an in-line parser model in a scoreboard class, random idling on both channels
// depends on aiff_pkg and aiff_chunk_sample_parser_unit
`timescale 1ns / 100ps

module testbench;
	import aiff_pkg::*;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] value;
		logic [3:0]  chan;
		logic        last;
		logic [1:0]  code;
	} parse_result_t;

	class aiff_scoreboard;
		parse_result_t     expected_q[$];
		int                fail_count;
		phase_t            phase;
		bit [31:0]         field_cnt, chunk_id, chunk_len, skip_offset, align_block, accum;
		longint unsigned   region_left, body_left, frame_stride, sound_left, sample_shift;
		bit [15:0]         channels, sample_bits;
		bit                rate_seen, err_seen;
		bit [1:0]          err_code;
		int unsigned       chan_pos, byte_in_sample;

		function new();
			fail_count = 0;
			configure(32'd0);
		endfunction

		function void configure(bit [31:0] region);
			phase = PH_ID;
			field_cnt = 0; chunk_id = 0; chunk_len = 0; skip_offset = 0; align_block = 0;
			accum = 0; region_left = region; body_left = 0; frame_stride = 0;
			sound_left = 0; sample_shift = 0; channels = 0; sample_bits = 0;
			rate_seen = 0; err_seen = 0; err_code = ERR_BITS; chan_pos = 0; byte_in_sample = 0;
		endfunction

		function void emit(logic [1:0] kind, logic [31:0] v, int unsigned ch, bit last,
				logic [1:0] code);
			parse_result_t r;
			r.kind = kind; r.value = v; r.chan = ch[3:0]; r.last = last; r.code = code;
			expected_q.push_back(r);
		endfunction

		function void fail(logic [1:0] code);
			err_seen = 1;
			err_code = code;
			phase = PH_ERR;
			emit(KIND_ERROR, 0, 0, 0, code);
		endfunction

		function int header_fault();
			if (sample_bits != 8 && sample_bits != 16 && sample_bits != 32) return ERR_BITS;
			if (channels == 0 || channels > MaxChannelsDefault) return ERR_CHANS;
			if (!rate_seen) return ERR_RATE;
			return -1;
		endfunction

		function void end_chunk(bit produced);
			int c;
			if (chunk_id == ID_COMM) begin
				c = header_fault();
				if (c >= 0) begin
					fail(c[1:0]);
					return;
				end
			end
			phase = PH_ID;
			field_cnt = 0;
			chunk_id = 0;
			if (region_left == 0) begin
				phase = PH_DONE;
				if (!produced) emit(KIND_DONE, 0, 0, 0, 0);
			end
		endfunction

		function void note_byte(bit [7:0] b);
			bit              produced;
			bit              last;
			int              c;
			bit [31:0]       pos, v;
			int unsigned     bps;
			longint unsigned frame_bytes, avail;
			produced = 0;
			if (err_seen) begin
				emit(KIND_ERROR, 0, 0, 0, err_code);
				return;
			end
			if (phase == PH_DONE) begin
				emit(KIND_DONE, 0, 0, 0, 0);
				return;
			end
			if (phase == PH_ID) begin
				if (field_cnt == 0) begin
					if (region_left == 0) begin
						phase = PH_DONE;
						emit(KIND_DONE, 0, 0, 0, 0);
						return;
					end
					if (region_left < 8) begin
						fail(ERR_OVERRUN);
						return;
					end
				end
				chunk_id = {chunk_id[23:0], b};
				region_left--;
				field_cnt++;
				if (field_cnt >= 4) begin
					field_cnt = 0;
					chunk_len = 0;
					phase = PH_SIZE;
				end
				return;
			end
			if (phase == PH_SIZE) begin
				chunk_len = {chunk_len[23:0], b};
				region_left--;
				field_cnt++;
				if (field_cnt < 4) return;
				field_cnt = 0;
				body_left = longint'(chunk_len) + chunk_len[0];
				if (body_left > region_left) begin
					fail(ERR_OVERRUN);
					return;
				end
				if (chunk_id == ID_COMM) begin
					channels = 0;
					sample_bits = 0;
					rate_seen = 0;
					phase = PH_BODY;
				end else if (chunk_id == ID_SSND) begin
					c = header_fault();
					if (c >= 0) begin
						fail(c[1:0]);
						return;
					end
					skip_offset = 0;
					align_block = 0;
					phase = PH_SSND_HDR;
				end else begin
					phase = PH_BODY;
				end
				if (body_left == 0) end_chunk(0);
				return;
			end
			region_left--;
			body_left--;
			pos = field_cnt;
			if (chunk_id == ID_COMM) begin
				if (pos < chunk_len) begin
					if (pos < 2) channels = {channels[7:0], b};
					else if (pos == 6 || pos == 7) sample_bits = {sample_bits[7:0], b};
					else if (pos == 8) begin
						if (b[6:0] != 0) rate_seen = 1;
					end else if (pos > 8 && pos < 18) begin
						if (b != 0) rate_seen = 1;
					end
				end
			end else if (phase == PH_SSND_HDR) begin
				if (pos < chunk_len) begin
					if (pos < 4) skip_offset = {skip_offset[23:0], b};
					else if (pos < 8) align_block = {align_block[23:0], b};
					if (pos == 7) begin
						frame_bytes = longint'(channels) * (sample_bits >> 3);
						avail = longint'(chunk_len) - 8;
						frame_stride = frame_bytes;
						if (align_block != 0 && frame_bytes % align_block != 0)
							frame_stride = frame_bytes + align_block - frame_bytes % align_block;
						sound_left = (avail >= skip_offset) ? avail - skip_offset : 0;
						sample_shift = 0;
						byte_in_sample = 0;
						accum = 0;
						chan_pos = 0;
						phase = (skip_offset != 0) ? PH_SKIP : PH_DATA;
					end
				end
			end else if (phase == PH_SKIP) begin
				skip_offset--;
				if (skip_offset == 0) phase = PH_DATA;
			end else if (phase == PH_DATA) begin
				bps = sample_bits >> 3;
				frame_bytes = longint'(channels) * bps;
				if (sample_shift == 0 && (frame_stride == 0 || sound_left < frame_stride)) begin
					phase = PH_BODY;
				end else begin
					if (sample_shift < frame_bytes && bps != 0) begin
						accum = {accum[23:0], b};
						byte_in_sample++;
						if (byte_in_sample >= bps) begin
							v = accum;
							last = (chan_pos + 1 >= channels);
							if (bps == 1 && v[7]) v[31:8] = '1;
							if (bps == 2 && v[15]) v[31:16] = '1;
							emit(KIND_SAMPLE, v, chan_pos, last, 0);
							produced = 1;
							chan_pos = last ? 0 : chan_pos + 1;
							byte_in_sample = 0;
							accum = 0;
						end
					end
					sample_shift++;
					if (sample_shift >= frame_stride) begin
						sample_shift = 0;
						sound_left -= frame_stride;
					end
				end
			end
			field_cnt++;
			if (body_left == 0) end_chunk(produced);
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			fail_count++;
		endtask

		task check_result(parse_result_t got);
			parse_result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result kind %0d", got.kind));
				return;
			end
			want = expected_q.pop_front();
			if (got != want)
				report($sformatf("got kind %0d val %h ch %0d last %0d code %0d, want %0d %h %0d %0d %0d",
					got.kind, got.value, got.chan, got.last, got.code,
					want.kind, want.value, want.chan, want.last, want.code));
		endtask
	endclass

	logic        clk, arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        in_valid, in_stall;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  out_kind, error_code;
	logic signed [31:0] sample_value;
	logic [3:0]  channel_index;
	logic        frame_last;

	aiff_chunk_sample_parser_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
		.out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
		.sample_value(sample_value), .channel_index(channel_index),
		.frame_last(frame_last), .error_code(error_code)
	);

	aiff_scoreboard sb = new();
	bit [7:0]       region_q[$];
	int             send_idle_pct, stall_pct;
	int unsigned    cycle_cnt = 0;
	int unsigned    bytes_sent;

	localparam int unsigned CycleLimit = 400000;
	localparam int          SettleCycles = 24;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CycleLimit) begin
			$display("aiff_chunk_sample_parser_unit test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({out_kind, sample_value, channel_index, frame_last, error_code});
		out_stall <= ($urandom % 100) < stall_pct;
	end

	task write_region(bit [31:0] v);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'd0; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		sb.configure(v);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task send_byte(bit [7:0] b);
		while (($urandom % 100) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_byte <= b;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task drain();
		in_valid <= 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task put32(bit [31:0] v);
		for (int i = 3; i >= 0; i--) region_q.push_back(v[8*i +: 8]);
	endtask

	// one region: usually header chunk, maybe foreign chunk, then usually sound chunk
	task build_region();
		bit [7:0]    comm_body[18];
		int unsigned chans, bits, len, n, bps;
		region_q.delete();
		chans = ($urandom % 6 == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
		if ($urandom % 12 == 0) chans = ($urandom % 2) ? 0 : $urandom_range(17, 65535);
		case ($urandom % 3)
			0: bits = 8;
			1: bits = 16;
			default: bits = 32;
		endcase
		if ($urandom % 12 == 0) bits = $urandom_range(0, 65535);
		foreach (comm_body[i]) comm_body[i] = 0;
		comm_body[0] = chans[15:8]; comm_body[1] = chans[7:0];
		for (int i = 2; i < 6; i++) comm_body[i] = 8'($urandom);
		comm_body[6] = bits[15:8]; comm_body[7] = bits[7:0];
		comm_body[8] = 8'($urandom);
		comm_body[9] = 8'($urandom);
		case ($urandom % 10)
			0: comm_body[9] = 0;
			1: begin comm_body[8] = 8'h80; comm_body[9] = 0; end
			2: comm_body[8 + $urandom_range(1, 9)] = 8'($urandom_range(1, 255));
			default: ;
		endcase
		if ($urandom % 10 == 0) comm_body[8] = 8'($urandom);
		if ($urandom % 10 != 0) begin
			len = ($urandom % 6 == 0) ? $urandom_range(0, 21) : 18;
			put32(ID_COMM);
			put32(len);
			for (int i = 0; i < len; i++)
				region_q.push_back(i < 18 ? comm_body[i] : 8'($urandom));
			if (len % 2) region_q.push_back(8'($urandom));
		end
		if ($urandom % 3 == 0) begin
			len = $urandom_range(0, 9);
			put32($urandom);
			put32(len);
			repeat (len + len % 2) region_q.push_back(8'($urandom));
		end
		bps = bits / 8;
		n = (chans <= 16 && bps <= 4) ? $urandom_range(1, 3) * chans * bps : 0;
		n = n + $urandom_range(0, 6);
		if (n > 120) n = $urandom_range(0, 120);
		len = ($urandom % 10 == 0) ? $urandom_range(0, 7) : 8 + n;
		put32($urandom % 8 == 0 ? $urandom : ID_SSND);
		put32(len);
		if (len >= 8) begin
			put32(($urandom % 8 == 0) ? $urandom : (($urandom % 2) ? $urandom_range(0, 4) : 0));
			case ($urandom % 4)
				0: put32($urandom_range(1, 8));
				1: put32($urandom);
				default: put32(0);
			endcase
			repeat (n) region_q.push_back(8'($urandom));
		end else begin
			repeat (len) region_q.push_back(8'($urandom));
		end
		if (len % 2) region_q.push_back(8'($urandom));
	endtask

	task run_region(bit [31:0] region, int extra);
		write_region(region);
		foreach (region_q[i]) send_byte(region_q[i]);
		repeat (extra) send_byte(8'($urandom));
		drain();
	endtask

	task run_random_regions(int unsigned quota);
		bit [31:0] region;
		bytes_sent = 0;
		while (bytes_sent < quota) begin
			build_region();
			region = region_q.size();
			case ($urandom % 8)
				0: region = region - (region < 12 ? region : $urandom_range(1, 12));
				1: region = region + $urandom_range(1, 10);
				default: ;
			endcase
			run_region(region, $urandom_range(0, 3));
		end
	endtask

	initial begin
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; in_byte = 0;
		send_idle_pct = 0; stall_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// empty region, too-short region, unbounded region
		region_q.delete();
		run_region(32'd0, 2);
		run_region(32'd5, 2);
		build_region();
		run_region(32'hFFFF_FFFF, 0);

		run_random_regions(375);
		send_idle_pct = 53;
		run_random_regions(375);
		send_idle_pct = 0; stall_pct = 53;
		run_random_regions(375);
		send_idle_pct = 7; stall_pct = 7;
		run_random_regions(375);

		if (sb.fail_count == 0 && sb.expected_q.size() == 0)
			$display("aiff_chunk_sample_parser_unit test passed");
		else
			$display("aiff_chunk_sample_parser_unit test failed");
		$finish;
	end

endmodule
